// File: sv/pru_pkg.sv
// ----------------------------------------------------------------------------
// Pixel replication upscaler package
// Shared types and constants for the upscaler front end, queue and top level.
// ----------------------------------------------------------------------------
package pru_pkg;

  localparam int unsigned PixW    = 24;
  localparam int unsigned ScaleW  = 7;
  localparam int unsigned InWidW  = 12;
  localparam int unsigned RowsW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned PadW    = 2;

  // Largest replication factor; larger settings are clamped to it.
  localparam logic [ScaleW-1:0] ScaleMax = ScaleW'(100);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgScale   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgInWidth = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgInRows  = 2'd2;

  // One result word per accepted input word.
  typedef struct packed {
    logic            taken;
    logic            out_valid;
    logic [PixW-1:0] pix;
    logic            row_end;
    logic [PadW-1:0] pad;
    logic            frame_end;
  } res_t;

endpackage

// File: sv/pru_front.sv
// ----------------------------------------------------------------------------
// Upscaler front end
// Loads one input row into the line store, then steps the replication
// counters one output pixel per accepted word and classifies each result.
// ----------------------------------------------------------------------------
module pru_front import pru_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               acc_i,
  input  logic               pix_valid_i,
  input  logic [PixW-1:0]    pix_in_i,
  output logic               res_valid_o,
  output res_t               res_o
);

  localparam int unsigned AddrW = $clog2(MAX_WIDTH);
  localparam int unsigned WidW  = AddrW + 1;
  localparam int unsigned CmpW  = (WidW > InWidW) ? WidW : InWidW;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'b01,
    MODE_EMIT = 2'b10
  } mode_e;

  mode_e mode_q, mode_d;

  logic [ScaleW-1:0] scale_q;
  logic [InWidW-1:0] in_width_q;
  logic [RowsW-1:0]  in_rows_q;

  logic [AddrW-1:0]  col_q, col_d;
  logic [ScaleW-1:0] across_q, across_d;
  logic [ScaleW-1:0] down_q, down_d;
  logic [RowsW-1:0]  row_q, row_d;

  logic [ScaleW-1:0] s_eff;
  logic [WidW-1:0]   w_eff;
  logic [RowsW-1:0]  rows_eff;
  logic              col_last, across_last, down_last, row_last;

  logic              mem_wr, mem_rd;
  logic [PixW-1:0]   mem_q [MAX_WIDTH];
  logic [PixW-1:0]   rd_data_q;

  logic              desc_valid_q;
  res_t              desc_d, desc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q    <= ScaleW'(1);
      in_width_q <= InWidW'(1);
      in_rows_q  <= RowsW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgScale:   scale_q    <= cfg_wdata_i[ScaleW-1:0];
        CfgInWidth: in_width_q <= cfg_wdata_i[InWidW-1:0];
        CfgInRows:  in_rows_q  <= cfg_wdata_i[RowsW-1:0];
        default: ;
      endcase
    end
  end

  // Effective limits: zero counts as one, oversize values are clamped.
  always_comb begin
    if (scale_q == '0) begin
      s_eff = ScaleW'(1);
    end else if (scale_q > ScaleMax) begin
      s_eff = ScaleMax;
    end else begin
      s_eff = scale_q;
    end
    if (in_width_q == '0) begin
      w_eff = WidW'(1);
    end else if (CmpW'(in_width_q) > CmpW'(MAX_WIDTH)) begin
      w_eff = WidW'(MAX_WIDTH);
    end else begin
      w_eff = WidW'(in_width_q);
    end
    rows_eff = (in_rows_q == '0) ? RowsW'(1) : in_rows_q;
  end

  assign col_last    = ({1'b0, col_q} + WidW'(1)) >= w_eff;
  assign across_last = ({1'b0, across_q} + 8'd1) >= {1'b0, s_eff};
  assign down_last   = ({1'b0, down_q} + 8'd1) >= {1'b0, s_eff};
  assign row_last    = ({1'b0, row_q} + 17'd1) >= {1'b0, rows_eff};

  always_comb begin
    mode_d    = mode_q;
    col_d     = col_q;
    across_d  = across_q;
    down_d    = down_q;
    row_d     = row_q;
    mem_wr    = 1'b0;
    mem_rd    = 1'b0;
    desc_d    = '0;
    if (acc_i) begin
      unique case (mode_q)
        MODE_LOAD: begin
          if (pix_valid_i) begin
            mem_wr       = 1'b1;
            desc_d.taken = 1'b1;
            if (col_last) begin
              mode_d   = MODE_EMIT;
              col_d    = '0;
              across_d = '0;
            end else begin
              col_d = col_q + AddrW'(1);
            end
          end
        end
        MODE_EMIT: begin
          mem_rd           = 1'b1;
          desc_d.out_valid = 1'b1;
          if (across_last) begin
            across_d = '0;
            if (col_last) begin
              col_d          = '0;
              desc_d.row_end = 1'b1;
              // Only the low two bits of width times scale matter for padding.
              desc_d.pad     = PadW'(w_eff[1:0] * s_eff[1:0]);
              if (down_last) begin
                down_d = '0;
                mode_d = MODE_LOAD;
                if (row_last) begin
                  desc_d.frame_end = 1'b1;
                  row_d            = '0;
                end else begin
                  row_d = row_q + RowsW'(1);
                end
              end else begin
                down_d = down_q + ScaleW'(1);
              end
            end else begin
              col_d = col_q + AddrW'(1);
            end
          end else begin
            across_d = across_q + ScaleW'(1);
          end
        end
        default: mode_d = MODE_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_LOAD;
      col_q        <= '0;
      across_q     <= '0;
      down_q       <= '0;
      row_q        <= '0;
      desc_valid_q <= 1'b0;
    end else begin
      mode_q       <= mode_d;
      col_q        <= col_d;
      across_q     <= across_d;
      down_q       <= down_d;
      row_q        <= row_d;
      desc_valid_q <= acc_i;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
  end

  // Line store: one write or one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      mem_q[col_q] <= pix_in_i;
    end
    if (mem_rd) begin
      rd_data_q <= mem_q[col_q];
    end
  end

  always_comb begin
    res_o     = desc_q;
    res_o.pix = desc_q.out_valid ? rd_data_q : '0;
  end

  assign res_valid_o = desc_valid_q;

endmodule

// File: sv/pru_queue.sv
// ----------------------------------------------------------------------------
// Upscaler result queue
// Small FIFO between the front end and the output port; reports its fill
// level so the front end can hold off while results back up.
// ----------------------------------------------------------------------------
module pru_queue import pru_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  res_t                       push_data_i,
  input  logic                       pop_i,
  output logic                       not_empty_o,
  output res_t                       head_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  res_t            buf_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      count_q <= count_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign not_empty_o = (count_q != '0);
  assign head_o      = buf_q[rd_ptr_q];
  assign count_o     = count_q;

endmodule

// File: sv/pixel_replication_upscaler.sv
// ----------------------------------------------------------------------------
// Pixel replication upscaler
// Integer nearest-neighbor upscaler for a 24-bit pixel stream.
// ----------------------------------------------------------------------------
// Every word on the input stream is one tick and yields exactly one word on
// the output stream. While loading, a tick whose tuser flag is set stores
// its pixel in the line store and reports it as taken. Once a whole row is
// stored, each tick emits one pixel: every stored pixel is repeated scale
// times across and the row scale times down. The last pixel of an output
// row has tlast set and carries its padding byte count; the last pixel of
// the frame is flagged in tuser.
// Each accepted input word passes through the registered line-store read
// and the result queue before it reaches the output side. One word is
// accepted per cycle for as long as the output side takes them.
// When the receiver stalls, the four-entry result queue fills and the input
// side drops tready. Reset returns the block to loading the first row with
// scale, width and rows all one. The configuration port writes a register
// at any clock edge with the write enable high.
// ----------------------------------------------------------------------------
module pixel_replication_upscaler import pru_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [23:0]        s_axis_tdata,  // [23:0] pix_in
  input  logic [0:0]         s_axis_tuser,  // [0] pix_valid
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [31:0]        m_axis_tdata,  // [23:0] pix_out, [25:24] pad_bytes
  output logic               m_axis_tlast,  // row_end
  output logic [2:0]         m_axis_tuser,  // [0] taken, [1] out_valid, [2] frame_end
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  localparam int unsigned QDepth = 4;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  logic             acc;
  logic             res_valid;
  res_t             res;
  logic             pop;
  logic             q_not_empty;
  res_t             head;
  logic [QCntW-1:0] q_count;

  // Room is needed for every word already queued plus the one in flight.
  assign s_axis_tready = (q_count + QCntW'(res_valid)) < QCntW'(QDepth);
  assign acc           = s_axis_tvalid && s_axis_tready;

  pru_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .acc_i      (acc),
    .pix_valid_i(s_axis_tuser[0]),
    .pix_in_i   (s_axis_tdata),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  assign pop = m_axis_tvalid && m_axis_tready;

  pru_queue #(
    .DEPTH(QDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res),
    .pop_i      (pop),
    .not_empty_o(q_not_empty),
    .head_o     (head),
    .count_o    (q_count)
  );

  assign m_axis_tvalid = q_not_empty;
  assign m_axis_tdata  = {6'b0, head.pad, head.pix};
  assign m_axis_tlast  = head.row_end;
  assign m_axis_tuser  = {head.frame_end, head.out_valid, head.taken};

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pixel replication upscaler testbench
// Drives pixel words and register writes into the upscaler, predicts every
// output word with a word-by-word model of the replication counters and
// compares each delivered word field by field, under random stalls.
// ----------------------------------------------------------------------------
module tb;
  import pru_pkg::*;

  localparam int unsigned MaxWidth    = 2048;
  localparam int unsigned IdlePct     = 18;
  localparam int unsigned ValidPct    = 85;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned StallLimit  = 3000;
  localparam int unsigned RandomWords = 1000;
  localparam int unsigned SettleWait  = 4;

  // Index with no register behind it; a write there must change nothing.
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  class upscale_scoreboard;
    bit [PixW-1:0]   line_mem [MaxWidth];
    bit              emitting;
    int unsigned     col;
    int unsigned     across;
    int unsigned     down;
    int unsigned     row_idx;
    bit [ScaleW-1:0] scale_r = 1;
    bit [InWidW-1:0] width_r = 1;
    bit [RowsW-1:0]  rows_r = 1;
    int unsigned     stored_upto;
    int unsigned     frames;
    int unsigned     useful;
    int unsigned     errors;
    res_t            pending_q[$];

    function int unsigned width_of(bit [InWidW-1:0] raw);
      if (raw == 0) return 1;
      if (raw > MaxWidth) return MaxWidth;
      return raw;
    endfunction

    function int unsigned scale_now();
      if (scale_r == 0) return 1;
      if (scale_r > ScaleMax) return ScaleMax;
      return scale_r;
    endfunction

    function int unsigned rows_now();
      return (rows_r == 0) ? 1 : rows_r;
    endfunction

    function int unsigned waiting();
      return pending_q.size();
    endfunction

    function void set_reg(bit [CfgIdxW-1:0] idx, bit [CfgW-1:0] data);
      case (idx)
        CfgScale: begin
          scale_r = data[ScaleW-1:0];
        end
        CfgInWidth: begin
          width_r = data[InWidW-1:0];
        end
        CfgInRows: begin
          rows_r = data[RowsW-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    // One accepted input word is one tick of the upscaler.
    function void note_word(bit pv, bit [PixW-1:0] pix);
      res_t        e;
      int unsigned w;
      int unsigned s;
      int unsigned idx;
      w = width_of(width_r);
      s = scale_now();
      e = '0;
      idx = (col >= MaxWidth) ? MaxWidth - 1 : col;
      if (!emitting) begin
        if (pv) begin
          line_mem[idx] = pix;
          e.taken = 1'b1;
          if (idx + 1 > stored_upto) stored_upto = idx + 1;
          if (idx + 1 >= w) begin
            emitting = 1'b1;
            col = 0;
            across = 0;
          end else begin
            col = idx + 1;
          end
        end
      end else begin
        e.out_valid = 1'b1;
        e.pix = line_mem[idx];
        if (across + 1 >= s) begin
          across = 0;
          if (idx + 1 >= w) begin
            col = 0;
            e.row_end = 1'b1;
            e.pad = PadW'((w * s) % 4);
            if (down + 1 >= s) begin
              down = 0;
              emitting = 1'b0;
              if (row_idx + 1 >= rows_now()) begin
                e.frame_end = 1'b1;
                row_idx = 0;
                frames++;
              end else begin
                row_idx = (row_idx + 1) & 16'hFFFF;
              end
            end else begin
              down++;
            end
          end else begin
            col = idx + 1;
          end
        end else begin
          across++;
        end
      end
      if (e.taken || e.out_valid) useful++;
      pending_q.push_back(e);
    endfunction

    task report(string field, int unsigned got, int unsigned want);
      $display("mismatch on %s: got %0h, want %0h", field, got, want);
      errors++;
    endtask

    task check_word(res_t got);
      res_t want;
      if (pending_q.size() == 0) begin
        report("word with nothing pending", got.pix, 0);
        return;
      end
      want = pending_q.pop_front();
      if (got.taken !== want.taken) report("taken", got.taken, want.taken);
      if (got.out_valid !== want.out_valid) report("out_valid", got.out_valid, want.out_valid);
      if (got.pix !== want.pix) report("pix_out", got.pix, want.pix);
      if (got.row_end !== want.row_end) report("row_end", got.row_end, want.row_end);
      if (got.pad !== want.pad) report("pad_bytes", got.pad, want.pad);
      if (got.frame_end !== want.frame_end) report("frame_end", got.frame_end, want.frame_end);
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [23:0]        s_axis_tdata = '0;   // [23:0] pix_in
  logic [0:0]         s_axis_tuser = '0;   // [0] pix_valid
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [31:0]        m_axis_tdata;        // [23:0] pix_out, [25:24] pad_bytes
  logic               m_axis_tlast;
  logic [2:0]         m_axis_tuser;        // [0] taken, [1] out_valid, [2] frame_end
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0]    cfg_wdata_i = '0;

  bit          steady = 1'b0;
  int          hold_asks = 0;
  int          holds_done = 0;
  int          hold_left = 0;
  int unsigned stall_cycles = 0;

  upscale_scoreboard sb = new();

  pixel_replication_upscaler #(
    .MAX_WIDTH(MaxWidth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.taken     = m_axis_tuser[0];
      got.out_valid = m_axis_tuser[1];
      got.pix       = m_axis_tdata[PixW-1:0];
      got.row_end   = m_axis_tlast;
      got.pad       = m_axis_tdata[PixW+PadW-1:PixW];
      got.frame_end = m_axis_tuser[2];
      sb.check_word(got);
    end
  end

  // Receiver: random back-pressure, plus one long hold-off when asked for.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (holds_done != hold_asks) begin
      holds_done <= hold_asks;
      hold_left <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(99) >= IdlePct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_word(input bit pv, input logic [PixW-1:0] pix);
    while (!steady && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= PixW'($urandom);
      s_axis_tuser <= 1'($urandom);
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= pix;
    s_axis_tuser <= pv;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_word(pv, pix);
  endtask

  task automatic rand_word();
    send_word($urandom_range(99) < ValidPct, PixW'($urandom));
  endtask

  task automatic run_words(input int unsigned n);
    repeat (n) rand_word();
  endtask

  task automatic run_until_frame(input int unsigned cap);
    int unsigned start;
    int unsigned n;
    start = sb.frames;
    n = 0;
    while (sb.frames == start && n < cap) begin
      rand_word();
      n++;
    end
  endtask

  task automatic run_to_loading();
    while (sb.emitting) rand_word();
  endtask

  // Stops offering words and lets every pending word drain out.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // While a row is being emitted, the width may not grow past what the line
  // store already holds, or unwritten entries would be read.
  task automatic put_width(input logic [CfgW-1:0] raw);
    if (sb.emitting && sb.width_of(raw[InWidW-1:0]) > sb.stored_upto) raw = CfgW'(sb.stored_upto);
    write_reg(CfgInWidth, raw);
  endtask

  task automatic random_config();
    int unsigned r;
    r = $urandom_range(99);
    if ($urandom_range(99) < 60) begin
      if (r < 70) write_reg(CfgScale, CfgW'($urandom_range(1, 4)));
      else if (r < 80) write_reg(CfgScale, '0);
      else if (r < 90) write_reg(CfgScale, CfgW'($urandom_range(5, 8)));
      else write_reg(CfgScale, {9'($urandom), 7'($urandom_range(1, 3))});
    end
    r = $urandom_range(99);
    if ($urandom_range(99) < 60) begin
      if (r < 60) put_width(CfgW'($urandom_range(1, 12)));
      else if (r < 70) put_width('0);
      else if (r < 85) put_width(CfgW'($urandom_range(13, 40)));
      else put_width({4'($urandom), 12'($urandom_range(1, 10))});
    end
    r = $urandom_range(99);
    if ($urandom_range(99) < 60) begin
      if (r < 60) write_reg(CfgInRows, CfgW'($urandom_range(1, 3)));
      else if (r < 70) write_reg(CfgInRows, '0);
      else if (r < 75) write_reg(CfgInRows, CfgW'($urandom));
      else write_reg(CfgInRows, CfgW'($urandom_range(4, 6)));
    end
    if ($urandom_range(99) < 5) write_reg(CfgSpare, CfgW'($urandom));
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: one pixel wide, no scaling, one row.
    send_word(1'b0, 24'hFFFFFF);
    send_word(1'b1, 24'hFFFFFF);
    send_word(1'b1, 24'h123456);
    send_word(1'b1, 24'h000000);
    send_word(1'b0, 24'h000000);

    // Three pixels doubled gives a six-pixel row with two bytes of padding.
    settle();
    write_reg(CfgScale, CfgW'(2));
    put_width(CfgW'(3));
    write_reg(CfgInRows, CfgW'(1));
    send_word(1'b1, 24'hAAAAAA);
    send_word(1'b1, 24'h555555);
    send_word(1'b1, 24'h0F0F0F);
    run_words(12);

    // Zero in every register is read as one.
    settle();
    write_reg(CfgScale, '0);
    put_width('0);
    write_reg(CfgInRows, '0);
    write_reg(CfgSpare, 16'hFFFF);
    send_word(1'b1, 24'h800001);
    send_word(1'b1, 24'h7FFFFE);

    while (sb.useful < RandomWords) begin
      steady = (sb.useful >= 300 && sb.useful < 900);
      settle();
      random_config();
      if (hold_asks == 0 && sb.useful >= 150) hold_asks = 1;
      if ($urandom_range(1) == 1) run_until_frame(1500);
      else run_words($urandom_range(5, 120));
    end
    steady = 1'b0;

    // Largest replication: scale 101 in the low bits is clamped to 100.
    // Two output rows show where the row ends, then scale one ends the frame.
    run_to_loading();
    settle();
    write_reg(CfgScale, 16'hFFE5);
    put_width(CfgW'(1));
    write_reg(CfgInRows, CfgW'(1));
    run_words(250);
    settle();
    write_reg(CfgScale, CfgW'(1));
    run_until_frame(20);

    // Widest row: 2049 is clamped to the line store size, so loading ends
    // after 2048 pixels; narrowing the row then ends the frame at once.
    settle();
    write_reg(CfgScale, CfgW'(1));
    put_width(16'hF801);
    repeat (MaxWidth) send_word(1'b1, PixW'($urandom));
    settle();
    put_width(CfgW'(1));
    run_until_frame(20);

    // Long frame cut short by lowering scale and rows while emitting.
    settle();
    write_reg(CfgScale, CfgW'(100));
    put_width(CfgW'(1));
    write_reg(CfgInRows, 16'hFFFF);
    run_words(300);
    settle();
    write_reg(CfgScale, CfgW'(2));
    run_words(10);
    settle();
    write_reg(CfgInRows, '0);
    run_until_frame(200);

    settle();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.waiting() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
